>>> rtl/gb_pkg.sv
package gb_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int PIXEL_BITS = 8;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_LIMIT  = 512;
   localparam int ROW_BITS   = $clog2(ROW_LIMIT);
   localparam int DIM_BITS   = 10;
   // 1-2-1 kernel weights sum to 16: four guard bits
   localparam int SUM_BITS   = PIXEL_BITS + 4;

   localparam int REQ_DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((ROW_BITS + COL_BITS + PIXEL_BITS + 7) / 8) * 8;

   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      logic [PIXEL_BITS-1:0] value;
      logic                  last;
   } rsp_item_type;

   // up to two results per item, item0 first in stream order
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } fifo_push_type;

endpackage

>>> rtl/gb_line_ram.sv
module gb_line_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gb_rsp_fifo.sv
module gb_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  gb_pkg::fifo_push_type               push,
   input  logic                                out_ready,
   output logic                                out_valid,
   output gb_pkg::rsp_item_type                out_item,
   output logic [gb_pkg::FIFO_CNT_BITS-1:0]    level
);

   gb_pkg::rsp_item_type slot_ff [gb_pkg::FIFO_DEPTH];

   logic [gb_pkg::FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gb_pkg::FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gb_pkg::FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [gb_pkg::FIFO_PTR_BITS-1:0] wr_ptr_next;
   logic [1:0]                       n_push;
   logic                             pop;

   assign out_valid   = (count_ff != '0);
   assign out_item    = slot_ff[rd_ptr_ff];
   assign level       = count_ff;
   assign pop         = out_valid && out_ready;
   assign n_push      = 2'(push.push0) + 2'(push.push1);
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + gb_pkg::FIFO_PTR_BITS'(n_push);
      rd_ptr_in = rd_ptr_ff + gb_pkg::FIFO_PTR_BITS'(pop);
      count_in  = count_ff + gb_pkg::FIFO_CNT_BITS'(n_push)
                  - gb_pkg::FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         slot_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.push1) begin
         slot_ff[wr_ptr_next] <= push.item1;
      end
   end

endmodule

>>> rtl/gaussian_blur_3x3.sv
// 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1, sum >> 4) over a raster pixel stream.
//
// req_*: one item per pixel, tdata = intensity, tuser = frame start (forces row 0,
// column 0). rsp_*: one item per emitted pixel, tdata = {value, col, row}, tlast
// marks the last result caused by one input pixel (an input gives 0, 1 or 2).
// csr_*: write image_width (index 0) and image_height (index 1) while idle;
// csr_ready is always high. Both reset to 512; 0 acts as 1, width saturates at 512.
//
// Border pixels pass through the compute stage and the result FIFO once their input item is
// accepted. An interior centre (r-1, c-1) takes the same path when pixel (r, c) is accepted,
// just ahead of that pixel's own result when (r, c) is a border pixel.
// Throughput is one item per cycle while req_tready is high: the two line stores are read
// at accept time and written back in the next cycle, with a bypass for same-column
// back-to-back accesses (width 1, or a frame start right after column 0).
// Results queue in an 8-deep FIFO; req_tready drops only while the queue could not
// absorb two more results from the item in flight plus the one being offered, so a
// stalled receiver backs up the input after a few items and nothing is lost.
// Reset (synchronous, active high) empties the queue and returns to row 0, column 0;
// line store contents are not cleared, and what rows 0 and 1 read from them feeds no result.
module gaussian_blur_3x3 (
   input  logic                                 clock,
   input  logic                                 reset,
   // slave stream, tdata: pixel_value[7:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gb_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // tuser: frame_start
   input  logic                                 req_tuser,
   // master stream, tdata: out_row[8:0], out_col[17:9], out_value[25:18], zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [gb_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [gb_pkg::DIM_BITS-1:0]          csr_data
);

   localparam int RB = gb_pkg::ROW_BITS;
   localparam int CB = gb_pkg::COL_BITS;
   localparam int PB = gb_pkg::PIXEL_BITS;
   localparam int DB = gb_pkg::DIM_BITS;
   localparam int SB = gb_pkg::SUM_BITS;

   // ---------------- configuration ----------------
   logic [DB-1:0] width_ff, height_ff;
   logic [DB-1:0] eff_w, eff_h;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DB'(gb_pkg::MAX_WIDTH);
         height_ff <= DB'(gb_pkg::ROW_LIMIT);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gb_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            gb_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) begin
         eff_w = DB'(1);
      end else if (width_ff > DB'(gb_pkg::MAX_WIDTH)) begin
         eff_w = DB'(gb_pkg::MAX_WIDTH);
      end
      eff_h = height_ff;
      if (height_ff == '0) begin
         eff_h = DB'(1);
      end else if (height_ff > DB'(gb_pkg::ROW_LIMIT)) begin
         eff_h = DB'(gb_pkg::ROW_LIMIT);
      end
   end

   // ---------------- accept stage: position and line store read ----------------
   logic          accept;
   logic [PB-1:0] req_pix;
   logic [RB-1:0] row_ff, row_in;
   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] acc_row;
   logic [CB-1:0] acc_col;
   logic [RB-1:0] row_base;
   logic [CB-1:0] col_base;
   logic [DB-1:0] row_step, col_step;

   logic          s1_valid_ff;
   logic [PB-1:0] s1_pix_ff;
   logic [RB-1:0] s1_row_ff;
   logic [CB-1:0] s1_col_ff;
   logic          byp_ff, byp_in;
   logic [PB-1:0] byp_top_ff, byp_mid_ff;
   logic [gb_pkg::FIFO_CNT_BITS-1:0] fifo_level;

   assign req_pix = req_tdata[PB-1:0];
   assign accept  = req_tvalid && req_tready;

   // room for two results from the item in flight and two from this one
   assign req_tready = (fifo_level + (s1_valid_ff ? gb_pkg::FIFO_CNT_BITS'(2) : '0))
                       <= gb_pkg::FIFO_CNT_BITS'(gb_pkg::FIFO_DEPTH - 2);

   always_comb begin
      row_base = req_tuser ? '0 : row_ff;
      col_base = req_tuser ? '0 : col_ff;
      acc_row  = row_base;
      acc_col  = col_base;
      // position left beyond the image by a smaller width or height
      if ({1'b0, col_base} >= eff_w) begin
         acc_col  = '0;
         row_step = {1'b0, row_base} + 1'b1;
         acc_row  = row_step[RB-1:0];
         if (row_step >= eff_h) begin
            acc_row = '0;
         end
      end else begin
         row_step = {1'b0, row_base};
      end
      if ({1'b0, acc_row} >= eff_h) begin
         acc_row = '0;
      end
      // advance past this pixel
      col_step = {1'b0, acc_col} + 1'b1;
      row_in   = acc_row;
      col_in   = col_step[CB-1:0];
      if (col_step >= eff_w) begin
         col_in = '0;
         if (({1'b0, acc_row} + 1'b1) >= eff_h) begin
            row_in = '0;
         end else begin
            row_in = acc_row + 1'b1;
         end
      end
   end

   // the item in flight writes this column back at the same edge
   assign byp_in = s1_valid_ff && (s1_col_ff == acc_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         s1_valid_ff <= accept;
      end
   end

   // ---------------- compute stage ----------------
   logic [PB-1:0] above_q, above2_q;
   logic [PB-1:0] top, mid;
   logic [PB-1:0] win_ff [6];
   logic [SB-1:0] sum;
   logic          interior, border;
   gb_pkg::rsp_item_type  int_item, bord_item;
   gb_pkg::fifo_push_type push;

   assign top = byp_ff ? byp_top_ff : above2_q;
   assign mid = byp_ff ? byp_mid_ff : above_q;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_pix;
         s1_row_ff  <= acc_row;
         s1_col_ff  <= acc_col;
         byp_ff     <= byp_in;
         byp_top_ff <= mid;
         byp_mid_ff <= s1_pix_ff;
      end
      if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_pix_ff;
      end
   end

   gb_line_ram #(.DEPTH(gb_pkg::MAX_WIDTH), .WIDTH(PB)) u_line_above (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (acc_col),
      .rd_data (above_q)
   );

   gb_line_ram #(.DEPTH(gb_pkg::MAX_WIDTH), .WIDTH(PB)) u_line_two_above (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid),
      .rd_en   (accept),
      .rd_addr (acc_col),
      .rd_data (above2_q)
   );

   assign sum = SB'(win_ff[0]) + (SB'(win_ff[1]) << 1) + SB'(win_ff[2])
              + (SB'(win_ff[3]) << 1) + (SB'(win_ff[4]) << 2) + (SB'(win_ff[5]) << 1)
              + SB'(top) + (SB'(mid) << 1) + SB'(s1_pix_ff);

   assign interior = (s1_row_ff >= RB'(2)) && (s1_col_ff >= CB'(2));
   assign border   = (s1_row_ff == '0) || (s1_col_ff == '0)
                  || ({1'b0, s1_row_ff} == (eff_h - 1'b1))
                  || ({1'b0, s1_col_ff} == (eff_w - 1'b1));

   always_comb begin
      int_item.row    = s1_row_ff - 1'b1;
      int_item.col    = s1_col_ff - 1'b1;
      int_item.value  = sum[SB-1:4];
      int_item.last   = !border;
      bord_item.row   = s1_row_ff;
      bord_item.col   = s1_col_ff;
      bord_item.value = s1_pix_ff;
      bord_item.last  = 1'b1;
      push.push0      = s1_valid_ff && (interior || border);
      push.push1      = s1_valid_ff && interior && border;
      push.item0      = interior ? int_item : bord_item;
      push.item1      = bord_item;
   end

   // ---------------- result queue ----------------
   gb_pkg::rsp_item_type out_item;

   gb_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .level     (fifo_level)
   );

   assign rsp_tdata = gb_pkg::RSP_DATA_BITS'({out_item.value, out_item.col, out_item.row});
   assign rsp_tlast = out_item.last;

endmodule

>>> rtl/gb_checker.sv
module gb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [gb_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input logic                                 rsp_tlast
);

   localparam int RB = gb_pkg::ROW_BITS;
   localparam int CB = gb_pkg::COL_BITS;

   // queue empty and input open right after reset
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output not empty or input closed after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // an interior centre without tlast is always followed by its border pixel
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second result of a pair missing");

   // only interior centres can come without tlast
   a_interior_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[RB-1:0] != '0)
                                   && (rsp_tdata[RB+CB-1:RB] != '0))
      else $error("non-final result on the border");

endmodule

bind gaussian_blur_3x3 gb_checker u_gb_checker (.*);
